@@ hdl/sql_query_tokenizer_defines.svh @@
// ----------------------------------------------------------------------------
// SQL query tokenizer assertion macros
// Shared property forms for the checks at the end of the tokenizer.
// ----------------------------------------------------------------------------
`ifndef SQL_QUERY_TOKENIZER_DEFINES_SVH
`define SQL_QUERY_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SQT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sqt_pkg.sv @@
// ----------------------------------------------------------------------------
// SQL query tokenizer package
// Token and error codes, the result record and the reserved keyword table.
// ----------------------------------------------------------------------------
package sqt_pkg;

	localparam int unsigned POS_WIDTH_DEF = 16;
	localparam int unsigned KW_COUNT      = 30;
	localparam int unsigned RES_DEPTH     = 4;
	localparam int unsigned LEN_W         = 16;

	localparam logic [3:0] KIND_IDENT  = 4'd0;
	localparam logic [3:0] KIND_INT    = 4'd1;
	localparam logic [3:0] KIND_STRING = 4'd2;
	localparam logic [3:0] KIND_COMMA  = 4'd3;
	localparam logic [3:0] KIND_DOT    = 4'd4;
	localparam logic [3:0] KIND_LPAREN = 4'd5;
	localparam logic [3:0] KIND_RPAREN = 4'd6;
	localparam logic [3:0] KIND_STAR   = 4'd7;
	localparam logic [3:0] KIND_SEMI   = 4'd8;
	localparam logic [3:0] KIND_EQ     = 4'd9;
	localparam logic [3:0] KIND_NE     = 4'd10;
	localparam logic [3:0] KIND_LT     = 4'd11;
	localparam logic [3:0] KIND_LE     = 4'd12;
	localparam logic [3:0] KIND_GT     = 4'd13;
	localparam logic [3:0] KIND_GE     = 4'd14;
	localparam logic [3:0] KIND_END    = 4'd15;

	localparam logic [1:0] ERR_NONE         = 2'd0;
	localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
	localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	typedef struct packed {
		logic [7:0]       ech;
		logic [1:0]       err;
		logic [4:0]       kw;
		logic [LEN_W-1:0] vlen;
		logic [LEN_W-1:0] tlen;
		logic [LEN_W-1:0] start;
		logic [3:0]       kind;
		logic             last;
	} res_t;

	// Names are right-aligned with the first character in the highest used byte.
	localparam logic [63:0] KW_NAME [KW_COUNT] = '{
		"SELECT", "FROM", "WHERE", "AND", "OR", "AS", "JOIN", "INNER", "ON",
		"LEFT", "RIGHT", "OUTER", "ORDER", "BY", "ASC", "DESC", "GROUP", "COUNT",
		"SUM", "MIN", "MAX", "HAVING", "DISTINCT", "LIMIT", "NULL", "IS", "NOT",
		"IN", "EXISTS", "EXPLAIN"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd2,
		4'd4, 4'd5, 4'd5, 4'd5, 4'd2, 4'd3, 4'd4, 4'd5, 4'd5,
		4'd3, 4'd3, 4'd3, 4'd6, 4'd8, 4'd5, 4'd4, 4'd2, 4'd3,
		4'd2, 4'd6, 4'd7
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Keyword in buffer order: first character in byte 0.
	function automatic logic [63:0] kw_word(input int unsigned k);
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < int'(KW_LEN[k])) begin
				w[8*i +: 8] = KW_NAME[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
			end
		end
		return w;
	endfunction

	function automatic logic [4:0] kw_lookup(input logic [63:0] kw_buf,
			input logic [LEN_W-1:0] len, input logic ovf);
		logic [4:0] code;
		code = '0;
		if (!ovf && len <= LEN_W'(8)) begin
			for (int k = KW_COUNT - 1; k >= 0; k--) begin
				if (len[3:0] == KW_LEN[k] && kw_buf == kw_word(k)) begin
					code = 5'(k + 1);
				end
			end
		end
		return code;
	endfunction

endpackage

@@ hdl/sql_query_tokenizer.sv @@
// ----------------------------------------------------------------------------
// SQL query tokenizer
// Streaming lexer: one query byte in per transaction, tokens out as they close.
// ----------------------------------------------------------------------------
// Usage. Query bytes arrive on the s_ channel, one per transaction, with the
// byte in s_tdata and s_tlast raised on a separate transaction that marks the
// end of the query (its data byte is ignored). Tokens leave on the m_ channel,
// one per transaction; m_tlast is set on the final token caused by an input
// transaction. A byte can close a pending token and open another, so one input
// may yield two tokens; the end-of-query transaction always yields End.
// An accepted byte waits in the input register until the lexer step writes
// its tokens into the result queue; the first token is then valid on m_tvalid.
// The input side takes one transaction per cycle while the four-entry result
// queue has room for two tokens; the output side drains one token per cycle
// while m_tready is high, so the sustained rate is one byte per cycle unless
// bytes that yield two tokens outpace the receiver. When the receiver stalls,
// the queue fills and s_tready falls until it drains. Reset clears the lexer
// state, position counters and queue; no tokens are pending afterwards.
// ----------------------------------------------------------------------------
`include "sql_query_tokenizer_defines.svh"

module sql_query_tokenizer import sqt_pkg::*; #(
	parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_char
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
	                               // [35:20] token_length, [51:36] value_length,
	                               // [56:52] keyword_code, [58:57] error_code,
	                               // [66:59] error_char, [71:67] zero
	output logic        m_tlast    // last_of_run
);

	// Scanner modes.
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_IDENT = 3'd1;
	localparam logic [2:0] M_INT   = 3'd2;
	localparam logic [2:0] M_MINUS = 3'd3;
	localparam logic [2:0] M_STR   = 3'd4;
	localparam logic [2:0] M_STRQ  = 3'd5;
	localparam logic [2:0] M_LT    = 3'd6;
	localparam logic [2:0] M_GT    = 3'd7;

	localparam int unsigned PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
	localparam int unsigned PW    = POSITION_WIDTH;

	// Input register.
	logic       vld_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// Lexer state.
	logic [2:0]       mode_q, mode_d;
	logic [PW-1:0]    bpos_q, bpos_d;
	logic [PW-1:0]    spos_q, spos_d;
	logic [LEN_W-1:0] slen_q, slen_d;
	logic [LEN_W-1:0] vlen_q, vlen_d;
	logic [63:0]      kwbuf_q, kwbuf_d;
	logic             kwovf_q, kwovf_d;
	logic             halt_q, halt_d;

	// Result queue.
	res_t             res_mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic             fire, pop, consumed;
	logic             a_vld, b_vld;
	res_t             res_a, res_b, res_out;
	logic [4:0]       kw_code;
	logic [PW+15:0]   bpos_ext, spos_ext;
	logic [15:0]      bpos_rep, spos_rep;
	logic [1:0]       n_wr;

	// The lexer step runs when a byte waits and the queue can take two tokens.
	assign fire     = vld_s1 && (cnt_q <= CNT_W'(RES_DEPTH - 2));
	assign s_tready = !vld_s1 || fire;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	// Positions are reported in the low sixteen bits, zero-extended if narrower.
	assign bpos_ext = {16'b0, bpos_q};
	assign spos_ext = {16'b0, spos_q};
	assign bpos_rep = bpos_ext[15:0];
	assign spos_rep = spos_ext[15:0];

	assign kw_code = kw_lookup(kwbuf_q, slen_q, kwovf_q);

	// One lexer step. Result A is the token or error closed by this byte (or flushed at
	// end of query); result B is the token or error this byte forms on its own, or End.
	always_comb begin
		a_vld    = 1'b0;
		b_vld    = 1'b0;
		res_a    = '0;
		res_b    = '0;
		consumed = 1'b0;
		mode_d   = mode_q;
		bpos_d   = bpos_q;
		spos_d   = spos_q;
		slen_d   = slen_q;
		vlen_d   = vlen_q;
		kwbuf_d  = kwbuf_q;
		kwovf_d  = kwovf_q;
		halt_d   = halt_q;

		if (eoi_s1) begin
			if (!halt_q) begin
				res_a.start = spos_rep;
				unique case (mode_q)
					M_IDENT: begin
						a_vld      = 1'b1;
						res_a.kind = KIND_IDENT;
						res_a.tlen = slen_q;
						res_a.kw   = kw_code;
					end
					M_INT: begin
						a_vld      = 1'b1;
						res_a.kind = KIND_INT;
						res_a.tlen = slen_q;
					end
					M_MINUS: begin
						a_vld     = 1'b1;
						res_a.err = ERR_UNEXPECTED;
						res_a.ech = CH_MINUS;
					end
					M_STR: begin
						a_vld     = 1'b1;
						res_a.err = ERR_UNTERMINATED;
					end
					M_STRQ: begin
						a_vld      = 1'b1;
						res_a.kind = KIND_STRING;
						res_a.tlen = slen_q;
						res_a.vlen = vlen_q;
					end
					M_LT: begin
						a_vld      = 1'b1;
						res_a.kind = KIND_LT;
						res_a.tlen = LEN_W'(1);
					end
					M_GT: begin
						a_vld      = 1'b1;
						res_a.kind = KIND_GT;
						res_a.tlen = LEN_W'(1);
					end
					default: ;
				endcase
			end
			b_vld       = 1'b1;
			res_b.kind  = KIND_END;
			res_b.start = bpos_rep;
			mode_d      = M_IDLE;
			bpos_d      = '0;
			spos_d      = '0;
			slen_d      = '0;
			vlen_d      = '0;
			kwbuf_d     = '0;
			kwovf_d     = 1'b0;
			halt_d      = 1'b0;
		end else begin
			if (!halt_q) begin
				res_a.start = spos_rep;
				unique case (mode_q)
					M_IDENT: begin
						if (is_alpha(char_s1) || is_digit(char_s1) || char_s1 == CH_UNDER) begin
							if (slen_q < LEN_W'(8)) begin
								kwbuf_d[8*slen_q[2:0] +: 8] = to_upper(char_s1);
							end else begin
								kwovf_d = 1'b1;
							end
							slen_d   = sat_inc(slen_q);
							consumed = 1'b1;
						end else begin
							a_vld      = 1'b1;
							res_a.kind = KIND_IDENT;
							res_a.tlen = slen_q;
							res_a.kw   = kw_code;
							mode_d     = M_IDLE;
						end
					end
					M_INT: begin
						if (is_digit(char_s1)) begin
							slen_d   = sat_inc(slen_q);
							consumed = 1'b1;
						end else begin
							a_vld      = 1'b1;
							res_a.kind = KIND_INT;
							res_a.tlen = slen_q;
							mode_d     = M_IDLE;
						end
					end
					M_MINUS: begin
						consumed = 1'b1;
						if (is_digit(char_s1)) begin
							mode_d = M_INT;
							slen_d = sat_inc(slen_q);
						end else begin
							// A minus sign not followed by a digit halts the scan.
							a_vld     = 1'b1;
							res_a.err = ERR_UNEXPECTED;
							res_a.ech = CH_MINUS;
							mode_d    = M_IDLE;
							halt_d    = 1'b1;
						end
					end
					M_STR: begin
						slen_d   = sat_inc(slen_q);
						consumed = 1'b1;
						if (char_s1 == CH_QUOTE) begin
							mode_d = M_STRQ;
						end else begin
							vlen_d = sat_inc(vlen_q);
						end
					end
					M_STRQ: begin
						if (char_s1 == CH_QUOTE) begin
							// Doubled quote: one quote in the value, string continues.
							slen_d   = sat_inc(slen_q);
							vlen_d   = sat_inc(vlen_q);
							mode_d   = M_STR;
							consumed = 1'b1;
						end else begin
							a_vld      = 1'b1;
							res_a.kind = KIND_STRING;
							res_a.tlen = slen_q;
							res_a.vlen = vlen_q;
							mode_d     = M_IDLE;
						end
					end
					M_LT: begin
						a_vld  = 1'b1;
						mode_d = M_IDLE;
						priority if (char_s1 == CH_EQ) begin
							res_a.kind = KIND_LE;
							res_a.tlen = LEN_W'(2);
							consumed   = 1'b1;
						end else if (char_s1 == CH_GT) begin
							res_a.kind = KIND_NE;
							res_a.tlen = LEN_W'(2);
							consumed   = 1'b1;
						end else begin
							res_a.kind = KIND_LT;
							res_a.tlen = LEN_W'(1);
						end
					end
					M_GT: begin
						a_vld  = 1'b1;
						mode_d = M_IDLE;
						if (char_s1 == CH_EQ) begin
							res_a.kind = KIND_GE;
							res_a.tlen = LEN_W'(2);
							consumed   = 1'b1;
						end else begin
							res_a.kind = KIND_GT;
							res_a.tlen = LEN_W'(1);
						end
					end
					default: mode_d = M_IDLE;
				endcase

				if (!consumed && !halt_d) begin
					res_b.start = bpos_rep;
					priority if (is_space(char_s1)) begin
						// Whitespace only separates tokens.
					end else if (char_s1 == CH_QUOTE || is_alpha(char_s1) ||
							char_s1 == CH_UNDER || is_digit(char_s1) ||
							char_s1 == CH_MINUS || char_s1 == CH_LT || char_s1 == CH_GT) begin
						spos_d  = bpos_q;
						slen_d  = LEN_W'(1);
						vlen_d  = '0;
						kwbuf_d = '0;
						kwovf_d = 1'b0;
						priority if (char_s1 == CH_QUOTE) begin
							mode_d = M_STR;
						end else if (is_alpha(char_s1) || char_s1 == CH_UNDER) begin
							mode_d  = M_IDENT;
							kwbuf_d = {56'b0, to_upper(char_s1)};
						end else if (is_digit(char_s1)) begin
							mode_d = M_INT;
						end else if (char_s1 == CH_MINUS) begin
							mode_d = M_MINUS;
						end else if (char_s1 == CH_LT) begin
							mode_d = M_LT;
						end else begin
							mode_d = M_GT;
						end
					end else begin
						b_vld      = 1'b1;
						res_b.tlen = LEN_W'(1);
						unique case (char_s1)
							CH_COMMA: res_b.kind = KIND_COMMA;
							CH_DOT:   res_b.kind = KIND_DOT;
							CH_LPAR:  res_b.kind = KIND_LPAREN;
							CH_RPAR:  res_b.kind = KIND_RPAREN;
							CH_STAR:  res_b.kind = KIND_STAR;
							CH_SEMI:  res_b.kind = KIND_SEMI;
							CH_EQ:    res_b.kind = KIND_EQ;
							default: begin
								// Any other byte, including those above 127, halts the scan.
								res_b.tlen = '0;
								res_b.err  = ERR_UNEXPECTED;
								res_b.ech  = char_s1;
								halt_d     = 1'b1;
							end
						endcase
					end
				end
			end
			if (bpos_q != '1) begin
				bpos_d = bpos_q + 1'b1;
			end
		end

		res_a.last = !b_vld;
		res_b.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			bpos_q  <= '0;
			spos_q  <= '0;
			slen_q  <= '0;
			vlen_q  <= '0;
			kwbuf_q <= '0;
			kwovf_q <= 1'b0;
			halt_q  <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			bpos_q  <= bpos_d;
			spos_q  <= spos_d;
			slen_q  <= slen_d;
			vlen_q  <= vlen_d;
			kwbuf_q <= kwbuf_d;
			kwovf_q <= kwovf_d;
			halt_q  <= halt_d;
		end
	end

	// Result queue: up to two writes and one read per cycle.
	assign n_wr = fire ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;

	always_ff @(posedge clk) begin
		if (fire && a_vld) begin
			res_mem_q[wr_ptr_q] <= res_a;
		end
		if (fire && b_vld) begin
			res_mem_q[a_vld ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + n_wr);
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			cnt_q <= CNT_W'(cnt_q + CNT_W'(n_wr) - CNT_W'(pop));
		end
	end

	assign res_out  = res_mem_q[rd_ptr_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {5'b0, res_out.ech, res_out.err, res_out.kw, res_out.vlen,
	                   res_out.tlen, res_out.start, res_out.kind};
	assign m_tlast  = res_out.last;

	// The queue never holds more tokens than it has entries.
	`SQT_ASSERT_SAME(a_queue_bound, 1'b1, cnt_q <= CNT_W'(RES_DEPTH), "result queue overflow")
	// End of query returns the lexer to its reset state.
	`SQT_ASSERT_NEXT(a_eoi_rearm, fire && eoi_s1,
		mode_q == M_IDLE && !halt_q && bpos_q == '0, "lexer not rearmed after end of query")
	// While halted on an error, ordinary bytes produce no tokens.
	`SQT_ASSERT_SAME(a_halt_silent, fire && halt_q && !eoi_s1,
		!a_vld && !b_vld, "token produced while halted")

endmodule
